FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/rpfp_pkg.sv
// ----------------------------------------------------------------------------
// rpfp_pkg
// types and constants shared by the rpc frame receive parser
// ----------------------------------------------------------------------------
package rpfp_pkg;

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_PRE     = 3'd1,
    PH_HDR     = 3'd2,
    PH_CMD     = 3'd3,
    PH_ATYPE   = 3'd4,
    PH_ALEN    = 3'd5,
    PH_ADATA   = 3'd6,
    PH_DISCARD = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_AHDR   = 3'd1,
    KIND_ABYTE  = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LEN      = 3'd1,
    ERR_TIMEOUT  = 3'd2,
    ERR_PREAMBLE = 3'd3,
    ERR_CMD_LEN  = 3'd4,
    ERR_ARG_HDR  = 3'd5,
    ERR_ARG_LEN  = 3'd6
  } err_t;

  localparam logic [2:0] REG_MAX_FRAME_LEN   = 3'd0;
  localparam logic [2:0] REG_MAX_COMMAND_LEN = 3'd1;
  localparam logic [2:0] REG_MAX_ARG_COUNT   = 3'd2;
  localparam logic [2:0] REG_MAX_ARG_LEN     = 3'd3;
  localparam logic [2:0] REG_BYTE_GAP_TICKS  = 3'd4;

  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
  localparam logic [7:0] SYNC_0 = 8'h3C;
  localparam logic [7:0] SYNC_1 = 8'h24;
  localparam logic [7:0] SYNC_2 = 8'h4D;
  localparam logic [7:0] SYNC_3 = 8'h55;

  typedef struct packed {
    logic [7:0] max_frame_len;
    logic [4:0] max_command_len;
    logic [3:0] max_arg_count;
    logic [7:0] max_arg_len;
    logic [7:0] byte_gap_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] arg_length;
    logic [3:0] arg_index;
    logic [2:0] frame_status;
    err_t       error_code;
    logic       last;
  } res_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = SYNC_0;
      2'd1:    b = SYNC_1;
      2'd2:    b = SYNC_2;
      default: b = SYNC_3;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/rpfp_fifo.sv
// ----------------------------------------------------------------------------
// rpfp_fifo
// four-entry result queue, takes up to two results a cycle, gives one if ready
// ----------------------------------------------------------------------------
module rpfp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  rpfp_pkg::res_t  push0,
  input  rpfp_pkg::res_t  push1,
  output logic            room,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rpfp_pkg::res_t  pop_data
);

  rpfp_pkg::res_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign room      = (count_r <= 3'd2);
  assign pop_valid = (count_r != 3'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

endmodule

FILE: rtl/core/rpfp_parse.sv
// ----------------------------------------------------------------------------
// rpfp_parse
// frame parser state and per-item decode, up to two results per item
// ----------------------------------------------------------------------------
module rpfp_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            tick,
  input  logic [7:0]      din,
  input  rpfp_pkg::cfg_t  cfg,
  output logic [1:0]      push_cnt,
  output rpfp_pkg::res_t  push0,
  output rpfp_pkg::res_t  push1
);

  rpfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] frame_left_r, frame_left_nxt;
  logic [1:0] pre_pos_r, pre_pos_nxt;
  logic [4:0] cmd_left_r, cmd_left_nxt;
  logic [3:0] arg_cnt_r, arg_cnt_nxt;
  logic [7:0] arg_left_r, arg_left_nxt;
  logic [2:0] hdr_status_r, hdr_status_nxt;
  rpfp_pkg::err_t pend_err_r, pend_err_nxt;
  logic [7:0] gap_r, gap_nxt;
  logic [7:0] cur_type_r, cur_type_nxt;

  logic           main_v, close_v;
  rpfp_pkg::res_t main_res, close_res;
  logic [7:0]     left;
  logic [4:0]     clen;

  always_comb begin
    phase_nxt      = phase_r;
    frame_left_nxt = frame_left_r;
    pre_pos_nxt    = pre_pos_r;
    cmd_left_nxt   = cmd_left_r;
    arg_cnt_nxt    = arg_cnt_r;
    arg_left_nxt   = arg_left_r;
    hdr_status_nxt = hdr_status_r;
    pend_err_nxt   = pend_err_r;
    gap_nxt        = gap_r;
    cur_type_nxt   = cur_type_r;
    main_v         = 1'b0;
    close_v        = 1'b0;
    main_res       = '0;
    close_res      = '0;
    left           = frame_left_r - 8'd1;
    clen           = din[4:0];

    if (tick) begin
      if (phase_r == rpfp_pkg::PH_DISCARD) begin
        phase_nxt = rpfp_pkg::PH_LEN;
      end else if (phase_r != rpfp_pkg::PH_LEN) begin
        if (gap_r >= cfg.byte_gap_ticks) begin
          main_v              = 1'b1;
          main_res.kind       = rpfp_pkg::KIND_REJECT;
          main_res.error_code = rpfp_pkg::ERR_TIMEOUT;
          phase_nxt           = rpfp_pkg::PH_DISCARD;
        end else begin
          gap_nxt = gap_r + 8'd1;
        end
      end
    end else if (phase_r == rpfp_pkg::PH_LEN) begin
      if (din < rpfp_pkg::MIN_FRAME_LEN || din > cfg.max_frame_len) begin
        hdr_status_nxt      = '0;
        main_v              = 1'b1;
        main_res.kind       = rpfp_pkg::KIND_REJECT;
        main_res.error_code = rpfp_pkg::ERR_LEN;
        phase_nxt           = rpfp_pkg::PH_DISCARD;
      end else begin
        frame_left_nxt = din;
        pre_pos_nxt    = '0;
        cmd_left_nxt   = '0;
        arg_cnt_nxt    = '0;
        arg_left_nxt   = '0;
        hdr_status_nxt = '0;
        pend_err_nxt   = rpfp_pkg::ERR_NONE;
        gap_nxt        = '0;
        cur_type_nxt   = '0;
        phase_nxt      = rpfp_pkg::PH_PRE;
      end
    end else if (phase_r != rpfp_pkg::PH_DISCARD) begin
      gap_nxt        = '0;
      frame_left_nxt = left;
      if (pend_err_r == rpfp_pkg::ERR_NONE) begin
        case (phase_r)
          rpfp_pkg::PH_PRE: begin
            if (din != rpfp_pkg::sync_byte(pre_pos_r)) begin
              main_v              = 1'b1;
              main_res.kind       = rpfp_pkg::KIND_REJECT;
              main_res.error_code = rpfp_pkg::ERR_PREAMBLE;
              phase_nxt           = rpfp_pkg::PH_DISCARD;
            end else if (pre_pos_r == 2'd3) begin
              pre_pos_nxt = '0;
              phase_nxt   = rpfp_pkg::PH_HDR;
            end else begin
              pre_pos_nxt = pre_pos_r + 2'd1;
            end
          end
          rpfp_pkg::PH_HDR: begin
            hdr_status_nxt = din[7:5];
            if (clen == 5'd0 || clen > cfg.max_command_len || {3'd0, clen} > left) begin
              pend_err_nxt = rpfp_pkg::ERR_CMD_LEN;
            end else begin
              cmd_left_nxt = clen;
              phase_nxt    = rpfp_pkg::PH_CMD;
            end
          end
          rpfp_pkg::PH_CMD: begin
            main_v         = 1'b1;
            main_res.kind  = rpfp_pkg::KIND_CHAR;
            main_res.value = din;
            cmd_left_nxt   = cmd_left_r - 5'd1;
            if (cmd_left_nxt == 5'd0) begin
              phase_nxt = rpfp_pkg::PH_ATYPE;
            end
          end
          rpfp_pkg::PH_ATYPE: begin
            if (arg_cnt_r >= cfg.max_arg_count || left == 8'd0) begin
              pend_err_nxt = rpfp_pkg::ERR_ARG_HDR;
            end else begin
              cur_type_nxt = din;
              phase_nxt    = rpfp_pkg::PH_ALEN;
            end
          end
          rpfp_pkg::PH_ALEN: begin
            if (din > cfg.max_arg_len || din > left) begin
              pend_err_nxt = rpfp_pkg::ERR_ARG_LEN;
            end else begin
              main_v              = 1'b1;
              main_res.kind       = rpfp_pkg::KIND_AHDR;
              main_res.value      = cur_type_r;
              main_res.arg_length = din;
              main_res.arg_index  = arg_cnt_r;
              arg_cnt_nxt         = arg_cnt_r + 4'd1;
              arg_left_nxt        = din;
              phase_nxt = (din != 8'd0) ? rpfp_pkg::PH_ADATA : rpfp_pkg::PH_ATYPE;
            end
          end
          rpfp_pkg::PH_ADATA: begin
            main_v             = 1'b1;
            main_res.kind      = rpfp_pkg::KIND_ABYTE;
            main_res.value     = din;
            main_res.arg_index = arg_cnt_r - 4'd1;
            arg_left_nxt       = arg_left_r - 8'd1;
            if (arg_left_nxt == 8'd0) begin
              phase_nxt = rpfp_pkg::PH_ATYPE;
            end
          end
          default: begin
          end
        endcase
      end
      // frame closes on its last byte unless the preamble already failed
      if (left == 8'd0 && phase_nxt != rpfp_pkg::PH_DISCARD) begin
        close_v = 1'b1;
        if (pend_err_nxt != rpfp_pkg::ERR_NONE) begin
          close_res.kind       = rpfp_pkg::KIND_REJECT;
          close_res.error_code = pend_err_nxt;
        end else begin
          close_res.kind      = rpfp_pkg::KIND_ACCEPT;
          close_res.arg_index = arg_cnt_nxt;
        end
        phase_nxt = rpfp_pkg::PH_LEN;
      end
    end

    main_res.frame_status  = hdr_status_nxt;
    close_res.frame_status = hdr_status_nxt;
    main_res.last          = !close_v;
    close_res.last         = 1'b1;
  end

  always_comb begin
    push_cnt = 2'd0;
    push0    = main_v ? main_res : close_res;
    push1    = close_res;
    if (accept) begin
      push_cnt = {1'b0, main_v} + {1'b0, close_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rpfp_pkg::PH_LEN;
      frame_left_r <= '0;
      pre_pos_r    <= '0;
      cmd_left_r   <= '0;
      arg_cnt_r    <= '0;
      arg_left_r   <= '0;
      hdr_status_r <= '0;
      pend_err_r   <= rpfp_pkg::ERR_NONE;
      gap_r        <= '0;
      cur_type_r   <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      frame_left_r <= frame_left_nxt;
      pre_pos_r    <= pre_pos_nxt;
      cmd_left_r   <= cmd_left_nxt;
      arg_cnt_r    <= arg_cnt_nxt;
      arg_left_r   <= arg_left_nxt;
      hdr_status_r <= hdr_status_nxt;
      pend_err_r   <= pend_err_nxt;
      gap_r        <= gap_nxt;
      cur_type_r   <= cur_type_nxt;
    end
  end

endmodule

FILE: rtl/core/rpc_frame_receive_parser_unit.sv
// ----------------------------------------------------------------------------
// channel  | dir | handshake          | payload
// in_      | in  | tvalid/tready      | tdata byte, tuser tick flag
// out_     | out | tvalid/tready      | tdata result fields, tuser kind, tlast
// cfg_     | in  | psel/penable/pready| five limit registers at 4*i
//
// one input item per ready cycle; parser state updates in the accepting cycle
// results leave one per ready cycle from a four-entry queue, first one the next cycle
// the last byte of a frame can yield two results; in_tready drops while the
// queue holds three or more
// reset is synchronous active low; clears parser state and queue, presets registers
// ----------------------------------------------------------------------------
// rpc_frame_receive_parser_unit
// receive parser for length-prefixed rpc frames
// ----------------------------------------------------------------------------
module rpc_frame_receive_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data
  input  logic        in_tuser,   // [0] tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] value, [15:8] arg_length, [19:16] arg_index,
                                  // [22:20] frame_status, [25:23] error_code
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rpfp_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;
  logic           room;
  logic           accept;
  logic [1:0]     push_cnt;
  rpfp_pkg::res_t push0, push1, head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len   <= 8'd64;
      cfg_r.max_command_len <= 5'd16;
      cfg_r.max_arg_count   <= 4'd8;
      cfg_r.max_arg_len     <= 8'd32;
      cfg_r.byte_gap_ticks  <= 8'd10;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rpfp_pkg::REG_MAX_FRAME_LEN:   cfg_r.max_frame_len   <= cfg_pwdata[7:0];
        rpfp_pkg::REG_MAX_COMMAND_LEN: cfg_r.max_command_len <= cfg_pwdata[4:0];
        rpfp_pkg::REG_MAX_ARG_COUNT:   cfg_r.max_arg_count   <= cfg_pwdata[3:0];
        rpfp_pkg::REG_MAX_ARG_LEN:     cfg_r.max_arg_len     <= cfg_pwdata[7:0];
        rpfp_pkg::REG_BYTE_GAP_TICKS:  cfg_r.byte_gap_ticks  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rpfp_pkg::REG_MAX_FRAME_LEN:   cfg_prdata = {24'd0, cfg_r.max_frame_len};
      rpfp_pkg::REG_MAX_COMMAND_LEN: cfg_prdata = {27'd0, cfg_r.max_command_len};
      rpfp_pkg::REG_MAX_ARG_COUNT:   cfg_prdata = {28'd0, cfg_r.max_arg_count};
      rpfp_pkg::REG_MAX_ARG_LEN:     cfg_prdata = {24'd0, cfg_r.max_arg_len};
      rpfp_pkg::REG_BYTE_GAP_TICKS:  cfg_prdata = {24'd0, cfg_r.byte_gap_ticks};
      default:                       cfg_prdata = '0;
    endcase
  end

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  rpfp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .tick     (in_tuser),
    .din      (in_tdata),
    .cfg      (cfg_r),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (push1)
  );

  rpfp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tuser = head.kind;
  assign out_tlast = head.last;
  assign out_tdata = {6'd0, head.error_code, head.frame_status, head.arg_index,
                      head.arg_length, head.value};

endmodule

FILE: rtl/core/rpfp_checker.sv
// ----------------------------------------------------------------------------
// rpfp_checker
// port-level checks for the rpc frame receive parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);

  logic [35:0] out_bus;
  logic        err_none;
  logic        is_reject;
  logic        is_close;

  assign out_bus   = {out_tlast, out_tuser, out_tdata};
  assign err_none  = (out_tdata[25:23] == rpfp_pkg::ERR_NONE);
  assign is_reject = (out_tuser == rpfp_pkg::KIND_REJECT);
  assign is_close  = is_reject || (out_tuser == rpfp_pkg::KIND_ACCEPT);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_bus))
  `ASSERT_IMPLY(a_reject_err, clk, rst_n, out_tvalid && is_reject, !err_none)
  `ASSERT_IMPLY(a_other_no_err, clk, rst_n, out_tvalid && !is_reject, err_none)
  `ASSERT_IMPLY(a_close_last, clk, rst_n, out_tvalid && is_close, out_tlast)
  `ASSERT_IMPLY(a_pready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind rpc_frame_receive_parser_unit rpfp_checker u_rpfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

FILE: dv/tb_rpc_frame_receive_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_rpc_frame_receive_parser_unit
// self-checking bench for the rpc frame receive parser: a behavioral parser
// runs on every accepted byte or tick and queues the results it should emit;
// each result leaving the block is compared field by field with the oldest
// one. directed frames cover the length, preamble, timeout and decode
// errors, then random frames with occasional corruption run under several
// limit settings, with random gaps on the input and stalls on the output
// ----------------------------------------------------------------------------
module tb_rpc_frame_receive_parser_unit;
  import rpfp_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rpc_frame_receive_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // limits as last written
  logic [7:0] lim_frame;
  logic [4:0] lim_cmd;
  logic [3:0] lim_args;
  logic [7:0] lim_arg_len;
  logic [7:0] lim_gap;

  // parser state
  phase_t     ph;
  logic [7:0] bytes_left;
  logic [1:0] pre_pos;
  logic [4:0] cmd_left;
  logic [3:0] n_args;
  logic [7:0] data_left;
  logic [2:0] hdr_status;
  err_t       latched_err;
  logic [7:0] tick_count;
  logic [7:0] arg_type;

  logic [7:0] preamble_bytes [4];

  res_t parser_results_due [$];
  res_t want_res;
  int   mismatches = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  bit   burst_mode = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic reset_parser_model();
    lim_frame = 8'd64;
    lim_cmd = 5'd16;
    lim_args = 4'd8;
    lim_arg_len = 8'd32;
    lim_gap = 8'd10;
    ph = PH_LEN;
    bytes_left = '0;
    pre_pos = '0;
    cmd_left = '0;
    n_args = '0;
    data_left = '0;
    hdr_status = '0;
    latched_err = ERR_NONE;
    tick_count = '0;
    arg_type = '0;
    preamble_bytes = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3};
  endtask

  function automatic res_t make_result(input kind_t k, input logic [7:0] v,
                                       input logic [7:0] len, input logic [3:0] idx,
                                       input err_t e);
    res_t r;
    r.kind = k;
    r.value = v;
    r.arg_length = len;
    r.arg_index = idx;
    r.frame_status = hdr_status;
    r.error_code = e;
    r.last = 1'b0;
    return r;
  endfunction

  // advance the parser by one byte or tick and queue what it emits
  task automatic parse_item(input logic tick, input logic [7:0] b);
    res_t       batch [$];
    logic [7:0] left;
    logic [4:0] c;
    if (tick) begin
      if (ph == PH_DISCARD) begin
        ph = PH_LEN;
      end else if (ph != PH_LEN) begin
        if (tick_count >= lim_gap) begin
          batch.push_back(make_result(KIND_REJECT, 8'd0, 8'd0, 4'd0, ERR_TIMEOUT));
          ph = PH_DISCARD;
        end else begin
          tick_count++;
        end
      end
    end else if (ph == PH_LEN) begin
      if (b < MIN_FRAME_LEN || b > lim_frame) begin
        hdr_status = '0;
        batch.push_back(make_result(KIND_REJECT, 8'd0, 8'd0, 4'd0, ERR_LEN));
        ph = PH_DISCARD;
      end else begin
        bytes_left = b;
        pre_pos = '0;
        cmd_left = '0;
        n_args = '0;
        data_left = '0;
        hdr_status = '0;
        latched_err = ERR_NONE;
        tick_count = '0;
        arg_type = '0;
        ph = PH_PRE;
      end
    end else if (ph != PH_DISCARD) begin
      tick_count = '0;
      bytes_left = bytes_left - 8'd1;
      left = bytes_left;
      if (latched_err == ERR_NONE) begin
        case (ph)
          PH_PRE: begin
            if (b != preamble_bytes[pre_pos]) begin
              batch.push_back(make_result(KIND_REJECT, 8'd0, 8'd0, 4'd0, ERR_PREAMBLE));
              ph = PH_DISCARD;
            end else if (pre_pos == 2'd3) begin
              pre_pos = '0;
              ph = PH_HDR;
            end else begin
              pre_pos++;
            end
          end
          PH_HDR: begin
            c = b[4:0];
            hdr_status = b[7:5];
            if (c == 5'd0 || c > lim_cmd || {3'd0, c} > left) begin
              latched_err = ERR_CMD_LEN;
            end else begin
              cmd_left = c;
              ph = PH_CMD;
            end
          end
          PH_CMD: begin
            batch.push_back(make_result(KIND_CHAR, b, 8'd0, 4'd0, ERR_NONE));
            cmd_left = cmd_left - 5'd1;
            if (cmd_left == 5'd0) ph = PH_ATYPE;
          end
          PH_ATYPE: begin
            if (n_args >= lim_args || left == 8'd0) begin
              latched_err = ERR_ARG_HDR;
            end else begin
              arg_type = b;
              ph = PH_ALEN;
            end
          end
          PH_ALEN: begin
            if (b > lim_arg_len || b > left) begin
              latched_err = ERR_ARG_LEN;
            end else begin
              batch.push_back(make_result(KIND_AHDR, arg_type, b, n_args, ERR_NONE));
              n_args = n_args + 4'd1;
              data_left = b;
              ph = (b != 8'd0) ? PH_ADATA : PH_ATYPE;
            end
          end
          PH_ADATA: begin
            batch.push_back(make_result(KIND_ABYTE, b, 8'd0, n_args - 4'd1, ERR_NONE));
            data_left = data_left - 8'd1;
            if (data_left == 8'd0) ph = PH_ATYPE;
          end
          default: begin
          end
        endcase
      end
      if (ph != PH_DISCARD && left == 8'd0) begin
        if (latched_err != ERR_NONE)
          batch.push_back(make_result(KIND_REJECT, 8'd0, 8'd0, 4'd0, latched_err));
        else
          batch.push_back(make_result(KIND_ACCEPT, 8'd0, 8'd0, n_args, ERR_NONE));
        ph = PH_LEN;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) parser_results_due.push_back(batch[i]);
  endtask

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(input logic tick, input logic [7:0] b);
    int gap;
    gap = pick_delay();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= tick;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    parse_item(tick, b);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_item(1'b0, bytes[i]);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  // hold the input and let every due result drain, then some slack
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (parser_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MAX_FRAME_LEN:   lim_frame = val;
      REG_MAX_COMMAND_LEN: lim_cmd = val[4:0];
      REG_MAX_ARG_COUNT:   lim_args = val[3:0];
      REG_MAX_ARG_LEN:     lim_arg_len = val;
      REG_BYTE_GAP_TICKS:  lim_gap = val;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic apply_limits(input logic [7:0] frame_len, input logic [7:0] cmd_len,
                              input logic [7:0] arg_count, input logic [7:0] arg_len,
                              input logic [7:0] gap_ticks);
    wait_for_drain();
    write_reg(REG_MAX_FRAME_LEN, frame_len);
    write_reg(REG_MAX_COMMAND_LEN, cmd_len);
    write_reg(REG_MAX_ARG_COUNT, arg_count);
    write_reg(REG_MAX_ARG_LEN, arg_len);
    write_reg(REG_BYTE_GAP_TICKS, gap_ticks);
  endtask

  // frame with random content, at times malformed, corrupted or cut short
  task automatic send_random_frame();
    logic [7:0] body [$];
    int ncmd, nargs, alen, r, k, pos;
    r = $urandom_range(0, 99);
    if (r < 4) ncmd = 0;
    else if (r < 8) ncmd = (lim_cmd == 5'd31) ? 31 : int'(lim_cmd) + 1;
    else if (r < 20) ncmd = $urandom_range(1, lim_cmd);
    else ncmd = $urandom_range(1, (lim_cmd < 4) ? lim_cmd : 4);
    body = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3};
    body.push_back({3'($urandom_range(0, 7)), 5'(ncmd)});
    repeat (ncmd) body.push_back(8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 6) nargs = int'(lim_args) + 1;
    else if (r < 20) nargs = $urandom_range(0, lim_args);
    else nargs = $urandom_range(0, (lim_args < 3) ? lim_args : 3);
    for (k = 0; k < nargs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) alen = (lim_arg_len == 8'd255) ? 255 : int'(lim_arg_len) + 1;
      else if (r < 12) alen = $urandom_range(0, lim_arg_len);
      else alen = $urandom_range(0, (lim_arg_len < 4) ? lim_arg_len : 4);
      if (body.size() + 2 + alen > 255) break;
      body.push_back(8'($urandom));
      body.push_back(8'(alen));
      repeat (alen) body.push_back(8'($urandom));
    end
    body.push_front(8'(body.size()));
    r = $urandom_range(0, 99);
    if (r < 12) begin
      pos = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ (8'd1 << $urandom_range(0, 7));
    end else if (r < 20) begin
      k = $urandom_range(1, body.size() - 1);
      repeat (k) void'(body.pop_back());
    end
    foreach (body[i]) begin
      if ($urandom_range(0, 99) < 3) send_tick();
      send_item(1'b0, body[i]);
    end
    // ticks until the parser waits for a length byte again
    while (ph != PH_LEN) send_tick();
  endtask

  task automatic run_random_frames(input int n_items);
    int stop_at, r;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      burst_mode = (r < 12);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
        while (ph != PH_LEN) send_tick();
      end else begin
        send_random_frame();
      end
      if ($urandom_range(0, 99) < 5) wait_for_drain();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_directed_frames();
    send_tick();
    send_bytes('{8'h04, 8'h00});
    send_tick();
    send_bytes('{8'hFF});
    send_tick();
    // command, zero length argument, two byte argument, accept
    send_bytes('{8'd12, SYNC_0, SYNC_1, SYNC_2, SYNC_3, 8'h01, 8'h5A,
                 8'hFF, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00});
    // type byte as last byte of the frame
    send_bytes('{8'd7, SYNC_0, SYNC_1, SYNC_2, SYNC_3, 8'hE1, 8'h41, 8'h12});
    // preamble mismatch
    send_bytes('{8'd5, SYNC_0, 8'h00});
    send_tick();
  endtask

  task automatic test_directed_limit_errors();
    apply_limits(8'd5, 8'd1, 8'd1, 8'd0, 8'd1);
    // byte timeout
    send_bytes('{8'd5, SYNC_0});
    send_tick();
    send_tick();
    send_tick();
    // zero command length
    send_bytes('{8'd5, SYNC_0, SYNC_1, SYNC_2, SYNC_3, 8'h00});
  endtask

  task automatic test_random_reset_limits();
    apply_limits(8'd64, 8'd16, 8'd8, 8'd32, 8'd10);
    run_random_frames(100);
  endtask

  task automatic test_random_wide_limits();
    apply_limits(8'd255, 8'd31, 8'd15, 8'd255, 8'd255);
    run_random_frames(40);
  endtask

  task automatic test_random_narrow_limits();
    apply_limits(8'd5, 8'd1, 8'd1, 8'd0, 8'd1);
    run_random_frames(50);
  endtask

  task automatic test_random_tight_limits();
    apply_limits(8'd40, 8'd3, 8'd2, 8'd5, 8'd2);
    run_random_frames(90);
  endtask

  task automatic test_random_any_limits();
    apply_limits(8'($urandom_range(5, 255)), 8'($urandom_range(1, 31)),
                 8'($urandom_range(1, 15)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(1, 255)));
    run_random_frames(40);
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!burst_mode && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_delay();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (parser_results_due.size() == 0) begin
        report_mismatch("result with none due", {29'd0, out_tuser}, 32'd0);
      end else begin
        want_res = parser_results_due.pop_front();
        if (out_tuser !== want_res.kind)
          report_mismatch("kind", 32'(out_tuser), 32'(want_res.kind));
        if (out_tdata[7:0] !== want_res.value)
          report_mismatch("value", 32'(out_tdata[7:0]), 32'(want_res.value));
        if (out_tdata[15:8] !== want_res.arg_length)
          report_mismatch("arg_length", 32'(out_tdata[15:8]), 32'(want_res.arg_length));
        if (out_tdata[19:16] !== want_res.arg_index)
          report_mismatch("arg_index", 32'(out_tdata[19:16]), 32'(want_res.arg_index));
        if (out_tdata[22:20] !== want_res.frame_status)
          report_mismatch("frame_status", 32'(out_tdata[22:20]),
                          32'(want_res.frame_status));
        if (out_tdata[25:23] !== want_res.error_code)
          report_mismatch("error_code", 32'(out_tdata[25:23]), 32'(want_res.error_code));
        if (out_tlast !== want_res.last)
          report_mismatch("last", 32'(out_tlast), 32'(want_res.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL rpc_frame_receive_parser_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_parser_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_directed_limit_errors();
    test_random_reset_limits();
    test_random_wide_limits();
    test_random_narrow_limits();
    test_random_tight_limits();
    test_random_any_limits();
    in_tvalid <= 1'b0;
    while (parser_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (parser_results_due.size() != 0)
      report_mismatch("results never seen", 32'd0, 32'(parser_results_due.size()));
    if (mismatches == 0)
      $display("PASS rpc_frame_receive_parser_unit");
    else
      $display("FAIL rpc_frame_receive_parser_unit");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rpfp_pkg.sv
rtl/core/rpfp_fifo.sv
rtl/core/rpfp_parse.sv
rtl/core/rpc_frame_receive_parser_unit.sv
rtl/core/rpfp_checker.sv
dv/tb_rpc_frame_receive_parser_unit.sv
